FILE: rtl/sts_pkg.sv
// Package for the simplex tableau solver: sizes, status codes, FSM states,
// and Q16.16 helper functions. No dependencies.
`default_nettype none
package sts_pkg;
	localparam int MAX_VARS_DEF = 8;
	localparam int MAX_EQS_DEF = 8;
	localparam logic [1:0] ST_OPTIMAL = 2'd0;
	localparam logic [1:0] ST_UNBOUNDED = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;
	localparam logic [1:0] REG_NUM_VARS = 2'd0;
	localparam logic [1:0] REG_NUM_EQS = 2'd1;
	localparam logic [1:0] REG_MAX_PIVOTS = 2'd2;

	typedef enum logic [4:0] {
		S_LOAD, S_OBJ_RD, S_OBJ_CMP, S_RAT_RD, S_RAT_RD2, S_RAT_DIV, S_RAT_CMP,
		S_PIV_RD, S_PIV_WAIT, S_NRM_RD, S_NRM_DIV, S_NRM_WR,
		S_ELF_RD, S_ELF_WAIT, S_EL_RDP, S_EL_RDX, S_EL_MUL, S_EL_WR,
		S_FIN_RD, S_FIN_WAIT, S_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	function automatic logic [31:0] sat32(input logic signed [64:0] v);
		if (v > 65'sd2147483647) return 32'h7fffffff;
		if (v < -65'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

FILE: rtl/sts_div.sv
// Sequential Q16.16 divider: (a*65536)/b truncated toward zero, saturated.
// One quotient bit per cycle. Depends on sts_pkg.
`default_nettype none
module sts_div
	import sts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire div_req_t    req,
	output logic             busy,
	output logic [31:0]      quot
);
	logic [47:0] rem_q, dvd_q, dvs_q;
	logic [47:0] q_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [48:0] trial;
	logic signed [64:0] sq;

	assign trial = {rem_q[46:0], dvd_q[47]} - {1'b0, dvs_q};
	assign busy = cnt_q != 6'd0;
	assign sq = neg_q ? -$signed({17'd0, q_q}) : $signed({17'd0, q_q});
	assign quot = sat32(sq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 6'd48;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[31] ^ req.den[31];
			dvd_q <= {(req.num[31] ? 32'd0 - req.num : req.num), 16'd0};
			dvs_q <= {16'd0, (req.den[31] ? 32'd0 - req.den : req.den)};
			rem_q <= '0;
			q_q <= '0;
		end else if (busy) begin
			dvd_q <= {dvd_q[46:0], 1'b0};
			if (!trial[48]) begin
				rem_q <= trial[47:0];
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[46:0], dvd_q[47]};
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/simplex_tableau_solver.sv
// Top level of the simplex tableau solver: load stream, APB registers,
// tableau memory and pivot sequencer. Depends on sts_pkg and sts_div.
//
// Usage: tableau entries (signed Q16.16) stream in on s_axis, row-major,
// num_eqs constraint rows then the objective row, each with
// num_vars+num_eqs coefficients and the right-hand side. One entry is taken
// per cycle while loading. The entry with tlast set starts the solve; no
// entry is taken until the result is delivered on m_axis.
// Result: tdata[1:0] = solve_status, tdata[33:2] = max_value, upper bits zero.
// Sequence: the objective scan reads each column but the right-hand side and
// picks the most negative entry; the ratio test reads each constraint row's
// pivot-column entry and right-hand side and starts the divider only for a
// positive entry; the pivot row is normalized column by column through the
// divider; each other row, the objective row included, is then eliminated column
// by column, and the scan starts again until the solve ends with a status.
// The tableau lives in one single-port synchronous RAM with registered read data.
// Reset clears the registers to 2, 2, 64 and returns to loading; the tableau
// is not cleared. A stalled receiver holds the result and blocks input.
`default_nettype none
module simplex_tableau_solver
	import sts_pkg::*;
#(
	parameter int MAX_VARS = MAX_VARS_DEF,
	parameter int MAX_EQS = MAX_EQS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // entry_value
	input  wire logic        s_axis_tlast,  // last_entry
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata   // [1:0] solve_status, [33:2] max_value, zero fill
);
	localparam int MaxCols = MAX_VARS + MAX_EQS + 1;
	localparam int Depth = (MAX_EQS + 1) * MaxCols;
	localparam int AW = $clog2(Depth + 1);
	localparam int CW = $clog2(MaxCols + 1);
	localparam int RW = $clog2(MAX_EQS + 2);

	logic [3:0] num_vars_q, num_eqs_q;
	logic [9:0] max_pivots_q, pcount_q;
	state_t state_q, state_d;

	// Register port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= 4'd2;
			num_eqs_q <= 4'd2;
			max_pivots_q <= 10'd64;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_NUM_VARS: num_vars_q <= pwdata[3:0];
				REG_NUM_EQS: num_eqs_q <= pwdata[3:0];
				REG_MAX_PIVOTS: max_pivots_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			REG_NUM_VARS: prdata = {28'd0, num_vars_q};
			REG_NUM_EQS: prdata = {28'd0, num_eqs_q};
			REG_MAX_PIVOTS: prdata = {22'd0, max_pivots_q};
			default: prdata = '0;
		endcase
	end

	// Effective layout
	logic [CW-1:0] nv, ne_c, cols, rhs;
	logic [RW-1:0] ne;
	logic [9:0] lim;
	always_comb begin
		nv = (num_vars_q == 4'd0) ? CW'(1)
			: ({28'd0, num_vars_q} > 32'(MAX_VARS)) ? CW'(MAX_VARS) : CW'(num_vars_q);
		ne_c = (num_eqs_q == 4'd0) ? CW'(1)
			: ({28'd0, num_eqs_q} > 32'(MAX_EQS)) ? CW'(MAX_EQS) : CW'(num_eqs_q);
		ne = RW'(ne_c);
		cols = nv + ne_c + CW'(1);
		rhs = cols - CW'(1);
		lim = (max_pivots_q == 10'd0) ? 10'd1 : max_pivots_q;
	end

	// Tableau memory
	logic [31:0] mem [Depth];
	logic [AW-1:0] addr;
	logic [31:0] wdata, rdata_q;
	logic we;
	always_ff @(posedge clk) begin
		if (we) mem[addr[$clog2(Depth)-1:0]] <= wdata;
		rdata_q <= mem[addr[$clog2(Depth)-1:0]];
	end

	// Sequencer registers
	logic [AW-1:0] load_idx_q;
	logic [RW-1:0] r_q, pr_q;
	logic [CW-1:0] c_q, pc_q;
	logic [31:0] best_q, theta_q, piv_q, f_q, rhsv_q, prv_q;
	logic found_q;
	logic [1:0] status_q;
	logic [31:0] value_q;
	logic signed [63:0] prod_s1;

	div_req_t dreq;
	logic dbusy;
	logic [31:0] dq;
	sts_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quot(dq));

	function automatic logic [AW-1:0] at(input logic [RW-1:0] r, input logic [CW-1:0] c,
		input logic [CW-1:0] nc);
		return AW'(r) * AW'(nc) + AW'(c);
	endfunction

	logic in_acc;
	assign s_axis_tready = state_q == S_LOAD;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = state_q == S_OUT;
	assign m_axis_tdata = {6'd0, value_q, status_q};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: if (in_acc && s_axis_tlast) state_d = S_OBJ_RD;
			S_OBJ_RD: state_d = S_OBJ_CMP;
			S_OBJ_CMP: begin
				if (c_q == rhs) begin
					state_d = ($signed(best_q) == 0) ? S_FIN_RD : S_RAT_RD;
				end else begin
					state_d = S_OBJ_RD;
				end
			end
			S_RAT_RD: begin
				if (r_q == ne) state_d = found_q ? ((pcount_q >= lim) ? S_OUT : S_PIV_RD) : S_OUT;
				else state_d = S_RAT_RD2;
			end
			S_RAT_RD2: state_d = S_RAT_DIV;
			S_RAT_DIV: begin
				if ($signed(prv_q) > 0) state_d = S_RAT_CMP;
				else state_d = S_RAT_RD;
			end
			S_RAT_CMP: if (!dbusy) state_d = S_RAT_RD;
			S_PIV_RD: state_d = S_PIV_WAIT;
			S_PIV_WAIT: state_d = S_NRM_RD;
			S_NRM_RD: state_d = (c_q == cols) ? S_ELF_RD : S_NRM_DIV;
			S_NRM_DIV: state_d = S_NRM_WR;
			S_NRM_WR: if (!dbusy) state_d = S_NRM_RD;
			S_ELF_RD: begin
				if ({1'b0, r_q} > {1'b0, ne}) state_d = S_OBJ_RD;
				else if (r_q == pr_q) state_d = S_ELF_RD;
				else state_d = S_ELF_WAIT;
			end
			S_ELF_WAIT: state_d = S_EL_RDP;
			S_EL_RDP: state_d = (c_q == cols) ? S_ELF_RD : S_EL_RDX;
			S_EL_RDX: state_d = S_EL_MUL;
			S_EL_MUL: state_d = S_EL_WR;
			S_EL_WR: state_d = S_EL_RDP;
			S_FIN_RD: state_d = S_FIN_WAIT;
			S_FIN_WAIT: state_d = S_OUT;
			S_OUT: if (m_axis_tready) state_d = S_LOAD;
			default: state_d = S_LOAD;
		endcase
	end

	// Memory and divider control
	always_comb begin
		addr = '0;
		we = 1'b0;
		wdata = s_axis_tdata;
		dreq = '0;
		case (state_q)
			S_LOAD: begin
				addr = load_idx_q;
				we = in_acc && (load_idx_q < AW'(Depth));
			end
			S_OBJ_RD: addr = at(ne, c_q, cols);
			S_RAT_RD: addr = at(r_q, pc_q, cols);
			S_RAT_RD2: addr = at(r_q, rhs, cols);
			S_RAT_DIV: begin
				dreq.start = $signed(prv_q) > 0;
				dreq.num = rdata_q;
				dreq.den = prv_q;
			end
			S_PIV_RD: addr = at(pr_q, pc_q, cols);
			S_NRM_RD: addr = at(pr_q, c_q, cols);
			S_NRM_DIV: begin
				dreq.start = 1'b1;
				dreq.num = rdata_q;
				dreq.den = piv_q;
			end
			S_NRM_WR: begin
				addr = at(pr_q, c_q, cols);
				we = !dbusy;
				wdata = dq;
			end
			S_ELF_RD: addr = at(r_q, pc_q, cols);
			S_EL_RDP: addr = at(pr_q, c_q, cols);
			S_EL_RDX: addr = at(r_q, c_q, cols);
			S_EL_WR: begin
				addr = at(r_q, c_q, cols);
				we = 1'b1;
				wdata = sat32(65'($signed(rhsv_q)) - 65'(prod_s1 / 65536));
			end
			S_FIN_RD: addr = at(ne, rhs, cols);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			load_idx_q <= '0;
			pcount_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LOAD && in_acc) begin
				if (load_idx_q < AW'(Depth)) load_idx_q <= load_idx_q + AW'(1);
				if (s_axis_tlast) pcount_q <= '0;
			end
			if (state_q == S_OUT && m_axis_tready) load_idx_q <= '0;
			if (state_q == S_PIV_RD) pcount_q <= pcount_q + 10'd1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				c_q <= '0;
				best_q <= '0;
				pc_q <= '0;
			end
			S_OBJ_CMP: begin
				// the right-hand side column takes no part in the entering choice
				if (c_q != rhs && $signed(rdata_q) < $signed(best_q)) begin
					best_q <= rdata_q;
					pc_q <= c_q;
				end
				c_q <= c_q + CW'(1);
				if (c_q == rhs) begin
					r_q <= '0;
					found_q <= 1'b0;
				end
			end
			S_OBJ_RD: if (c_q == rhs) c_q <= c_q; // rhs read is harmless
			S_RAT_RD: begin
				if (r_q == ne) begin
					if (!found_q) begin
						status_q <= ST_UNBOUNDED;
						value_q <= '0;
					end else if (pcount_q >= lim) begin
						status_q <= ST_LIMIT;
						value_q <= '0;
					end
				end
			end
			S_RAT_RD2: prv_q <= rdata_q;
			S_RAT_DIV: if ($signed(prv_q) <= 0) r_q <= r_q + RW'(1);
			S_RAT_CMP: begin
				if (!dbusy) begin
					if (!found_q || $signed(dq) < $signed(theta_q)) begin
						theta_q <= dq;
						pr_q <= r_q;
						found_q <= 1'b1;
					end
					r_q <= r_q + RW'(1);
				end
			end
			S_PIV_WAIT: begin
				piv_q <= rdata_q;
				c_q <= '0;
			end
			S_NRM_WR: if (!dbusy) c_q <= c_q + CW'(1);
			S_NRM_RD: if (c_q == cols) r_q <= '0;
			S_ELF_RD: begin
				if (r_q == pr_q) r_q <= r_q + RW'(1);
				c_q <= '0;
				if ({1'b0, r_q} > {1'b0, ne}) begin
					best_q <= '0;
					pc_q <= '0;
				end
			end
			S_ELF_WAIT: f_q <= rdata_q;
			S_EL_RDP: if (c_q == cols) r_q <= r_q + RW'(1);
			S_EL_MUL: rhsv_q <= rdata_q;
			S_EL_WR: c_q <= c_q + CW'(1);
			S_FIN_WAIT: begin
				status_q <= ST_OPTIMAL;
				value_q <= rdata_q;
			end
			default: ;
		endcase
		if (state_q == S_EL_RDX) prod_s1 <= $signed(f_q) * $signed(rdata_q);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input accepted while a result waits");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("bad status code");
endmodule
`default_nettype wire
